>>> rtl/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/mbc_pkg.sv
package mbc_pkg;

	localparam int GRID_W       = 6;
	localparam int IDX_W        = 10;
	localparam int STORE_DEPTH  = 1024;
	localparam int CNT_W        = 11;
	localparam int ALU_W        = 11;
	localparam int PROD_W       = 12;
	localparam int COORD_W      = 7;
	localparam int DRAW_W       = 5;
	localparam int DIV_STEPS    = 10;
	localparam int STEP_W       = 4;
	localparam int DIR_CNT_W    = 3;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;
	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;

	localparam logic [GRID_W-1:0]    GRID_RESET = GRID_W'(4);
	localparam logic [DIR_CNT_W-1:0] NBR_LAST   = DIR_CNT_W'(4);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [1:0] {
		ACT_CARVED = 2'd0,
		ACT_BACK   = 2'd1,
		ACT_DONE   = 2'd2,
		ACT_START  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_NBR,
		ST_PICK,
		ST_CLEAR,
		ST_EMIT
	} seq_state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	function automatic logic [1:0] draw_mod(input logic [DRAW_W-1:0] d,
	                                        input logic [2:0] n);
		logic [2:0] s;
		logic [1:0] m3;
		logic [1:0] res;
		s = 3'(d[1:0]) + 3'(d[3:2]) + 3'(d[4]);
		case (s) inside
			3'd0, 3'd3, 3'd6: m3 = 2'd0;
			3'd1, 3'd4, 3'd7: m3 = 2'd1;
			default:          m3 = 2'd2;
		endcase
		case (n)
			3'd1:    res = 2'd0;
			3'd2:    res = {1'b0, d[0]};
			3'd3:    res = m3;
			default: res = d[1:0];
		endcase
		return res;
	endfunction

	function automatic dir_t pick_dir(input logic [3:0] open_dirs, input logic [1:0] k);
		logic [2:0] seen;
		dir_t       res;
		seen = 3'd0;
		res  = DIR_N;
		for (int i = 0; i < 4; i++) begin
			if (open_dirs[i]) begin
				if (seen == 3'(k)) begin
					res = dir_t'(2'(i));
				end
				seen = seen + 3'd1;
			end
		end
		return res;
	endfunction

endpackage

>>> rtl/mbc_ram.sv
module mbc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/mbc_alu.sv
module mbc_alu
	import mbc_pkg::*;
(
	input  alu_req_t         req,
	output logic [ALU_W-1:0] sum
);

	always_comb begin
		unique case (req.op)
			ALU_ADD: sum = req.a + req.b;
			ALU_SUB: sum = req.a - req.b;
			default: sum = req.a;
		endcase
	end

endmodule

>>> rtl/maze_backtracker_carver.sv
// Depth-first maze carver. Registers: grid_rows at byte 0, grid_cols at byte 4, each clamped
// to 1..MAX_ROWS / 1..MAX_COLS when used. One request at a time, one result per request; a new
// request is taken while the previous result still waits on the output. A step request that
// carves or backtracks works this way: the stack top is divided by the column count in a
// ten-step restoring divide on the shared adder, then the four neighbour addresses go through
// the same adder and the single read port of the visited map one per cycle. A step after the
// maze is complete, or before any start, goes from the check straight to the emit state. A
// start request sweeps the whole 1024-entry visited map, one entry a cycle.
`include "assert_macros.svh"

module maze_backtracker_carver
	import mbc_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [DRAW_W-1:0]  random_draw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         action,
	output logic [COORD_W-1:0] wall_row,
	output logic [COORD_W-1:0] wall_col,
	output logic [CNT_W-1:0]   cells_visited
);

	seq_state_t state_q, state_d;

	logic [GRID_W-1:0]    grid_rows_q, grid_cols_q;
	logic [GRID_W-1:0]    rows_eff, cols_eff;
	logic [PROD_W-1:0]    prod_q;
	logic [CNT_W-1:0]     level_q, total_q;
	logic                 active_q;
	logic [DRAW_W-1:0]    draw_q;
	logic [IDX_W-1:0]     top_q, quo_q, clr_q;
	logic [GRID_W-1:0]    rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIR_CNT_W-1:0] dir_q;
	logic [3:0]           free_q;
	action_t              res_act_q;
	logic [COORD_W-1:0]   res_wr_q, res_wc_q;
	logic                 out_valid_q;
	action_t              action_q;
	logic [COORD_W-1:0]   wall_row_q, wall_col_q;
	logic [CNT_W-1:0]     visited_q;

	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_sum;
	logic [GRID_W:0]    shifted;
	logic               ge;
	logic [3:0]         edge_ok;
	logic [2:0]         open_cnt;
	dir_t               chosen;
	dir_t               dir_sel;
	logic [1:0]         prev_dir;
	logic               carve;
	logic               done_now;
	logic               out_free;
	logic               cfg_wr;
	logic [COORD_W-1:0] wr_calc, wc_calc;

	logic             vis_we;
	logic [IDX_W-1:0] vis_waddr, vis_raddr;
	logic [0:0]       vis_wdata, vis_rdata;
	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(grid_cols_q) : APB_DW'(grid_rows_q);

	always_comb begin
		if (grid_rows_q == '0) begin
			rows_eff = GRID_W'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows_eff = GRID_W'(MAX_ROWS);
		end else begin
			rows_eff = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			cols_eff = GRID_W'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			cols_eff = GRID_W'(MAX_COLS);
		end else begin
			cols_eff = grid_cols_q;
		end
	end

	assign shifted  = {rem_q, quo_q[IDX_W-1]};
	assign ge       = !alu_sum[ALU_W-1];
	assign edge_ok  = {rem_q != '0,
	                   (ALU_W'(quo_q) + ALU_W'(1)) < ALU_W'(rows_eff),
	                   ((GRID_W+1)'(rem_q) + (GRID_W+1)'(1)) < (GRID_W+1)'(cols_eff),
	                   quo_q != '0};
	assign open_cnt = 3'($countones(free_q));
	assign chosen   = pick_dir(free_q, draw_mod(draw_q, open_cnt));
	assign carve    = (open_cnt != 3'd0) && !level_q[CNT_W-1];
	assign dir_sel  = (state_q == ST_NBR) ? dir_t'(dir_q[1:0]) : chosen;
	assign prev_dir = dir_q[1:0] - 2'd1;
	assign done_now = !active_q || (PROD_W'(total_q) >= prod_q) || (level_q == '0);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		wr_calc = COORD_W'({quo_q[GRID_W-1:0], 1'b1});
		wc_calc = COORD_W'({rem_q, 1'b1});
		unique case (chosen)
			DIR_N:   wr_calc = COORD_W'({quo_q[GRID_W-1:0], 1'b0});
			DIR_E:   wc_calc = COORD_W'({rem_q, 1'b0}) + COORD_W'(2);
			DIR_S:   wr_calc = COORD_W'({quo_q[GRID_W-1:0], 1'b0}) + COORD_W'(2);
			DIR_W:   wc_calc = COORD_W'({rem_q, 1'b0});
			default: wr_calc = COORD_W'({quo_q[GRID_W-1:0], 1'b1});
		endcase
	end

	always_comb begin
		alu_req.a = ALU_W'(top_q);
		unique case (dir_sel)
			DIR_N: begin
				alu_req.op = ALU_SUB;
				alu_req.b  = ALU_W'(cols_eff);
			end
			DIR_E: begin
				alu_req.op = ALU_ADD;
				alu_req.b  = ALU_W'(1);
			end
			DIR_S: begin
				alu_req.op = ALU_ADD;
				alu_req.b  = ALU_W'(cols_eff);
			end
			default: begin
				alu_req.op = ALU_SUB;
				alu_req.b  = ALU_W'(1);
			end
		endcase
		if (state_q == ST_DIV) begin
			alu_req.op = ALU_SUB;
			alu_req.a  = ALU_W'(shifted);
			alu_req.b  = ALU_W'(cols_eff);
		end
	end

	mbc_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	always_comb begin
		state_d   = state_q;
		vis_we    = 1'b0;
		vis_waddr = alu_sum[IDX_W-1:0];
		vis_wdata = 1'b1;
		vis_raddr = alu_sum[IDX_W-1:0];
		stk_we    = 1'b0;
		stk_waddr = level_q[IDX_W-1:0];
		stk_wdata = alu_sum[IDX_W-1:0];
		stk_raddr = IDX_W'(level_q - CNT_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (operation == OP_START) ? ST_CLEAR : ST_CHECK;
				end
			end
			ST_CHECK: state_d = done_now ? ST_EMIT : ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_NBR;
				end
			end
			ST_NBR: begin
				if (dir_q == NBR_LAST) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				vis_we  = carve;
				stk_we  = carve;
				state_d = ST_EMIT;
			end
			ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = (clr_q == '0);
				stk_we    = (clr_q == '0);
				stk_waddr = '0;
				stk_wdata = '0;
				if (clr_q == '1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	mbc_ram #(
		.WIDTH (1),
		.DEPTH (STORE_DEPTH)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	mbc_ram #(
		.WIDTH (IDX_W),
		.DEPTH (STORE_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			prod_q      <= '0;
			level_q     <= '0;
			total_q     <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			dir_q       <= '0;
			clr_q       <= '0;
		end else begin
			state_q <= state_d;
			prod_q  <= PROD_W'(rows_eff) * PROD_W'(cols_eff);
			if (cfg_wr && pready) begin
				if (paddr[2] == REG_COLS) begin
					grid_cols_q <= pwdata[GRID_W-1:0];
				end else begin
					grid_rows_q <= pwdata[GRID_W-1:0];
				end
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: clr_q <= '0;
				ST_CHECK: begin
					if (active_q && done_now) begin
						active_q <= 1'b0;
					end
				end
				ST_LOAD: step_q <= '0;
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					dir_q  <= '0;
				end
				ST_NBR: dir_q <= dir_q + DIR_CNT_W'(1);
				ST_PICK: begin
					if (carve) begin
						level_q <= level_q + CNT_W'(1);
						total_q <= total_q + CNT_W'(1);
					end else begin
						level_q <= level_q - CNT_W'(1);
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == '1) begin
						level_q  <= CNT_W'(1);
						total_q  <= CNT_W'(1);
						active_q <= 1'b1;
					end
				end
				ST_EMIT: clr_q <= '0;
				default: clr_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			draw_q <= random_draw;
		end
		unique case (state_q)
			ST_CHECK: begin
				res_act_q <= ACT_DONE;
				res_wr_q  <= '0;
				res_wc_q  <= '0;
			end
			ST_LOAD: begin
				top_q <= stk_rdata;
				quo_q <= stk_rdata;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? alu_sum[GRID_W-1:0] : shifted[GRID_W-1:0];
				quo_q <= {quo_q[IDX_W-2:0], ge};
				free_q <= '0;
			end
			ST_NBR: begin
				if (dir_q != '0) begin
					free_q[prev_dir] <= !vis_rdata[0] && edge_ok[prev_dir];
				end
			end
			ST_PICK: begin
				res_act_q <= carve ? ACT_CARVED : ACT_BACK;
				res_wr_q  <= carve ? wr_calc : '0;
				res_wc_q  <= carve ? wc_calc : '0;
			end
			ST_CLEAR: begin
				res_act_q <= ACT_START;
				res_wr_q  <= '0;
				res_wc_q  <= '0;
			end
			ST_EMIT: begin
				if (out_free) begin
					action_q   <= res_act_q;
					wall_row_q <= res_wr_q;
					wall_col_q <= res_wc_q;
					visited_q  <= total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign wall_row      = wall_row_q;
	assign wall_col      = wall_col_q;
	assign cells_visited = visited_q;

	`ASSERT_PROP(a_level_le_total, clk, arst_n, level_q <= total_q,
		"path depth exceeds visited count")
	`ASSERT_NEXT(a_start_sweeps, clk, arst_n,
		in_valid && !in_stall && operation == OP_START, state_q == ST_CLEAR,
		"start request did not enter the clearing sweep")
	`ASSERT_PROP(a_carve_wall, clk, arst_n,
		(out_valid && action == ACT_CARVED) |-> (wall_row[0] != wall_col[0]),
		"carved wall does not lie between two cells")
	`ASSERT_PROP(a_result_from_emit, clk, arst_n,
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT),
		"result raised outside the emit step")

endmodule
